>>> design/qds_pkg.sv
package qds_pkg;

	localparam logic [30:0] SCALE_RESET = 31'd819200000;
	localparam logic [31:0] SPEED_SAT = 32'd2147483647;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CW,
		KIND_CCW,
		KIND_ILLEGAL
	} move_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

	localparam logic signed [1:0] STEP_NONE = 2'sb00;
	localparam logic signed [1:0] STEP_CW = 2'sb01;
	localparam logic signed [1:0] STEP_CCW = 2'sb11;

	// Transition between the previous and the new Gray code.
	function automatic move_kind_t move_kind(input logic [1:0] prev, input logic [1:0] code);
		move_kind_t kind;
		case ({prev, code}) inside
			4'b0001, 4'b0111, 4'b1000, 4'b1110: kind = KIND_CW;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: kind = KIND_CCW;
			4'b0011, 4'b0110, 4'b1001, 4'b1100: kind = KIND_ILLEGAL;
			default: kind = KIND_NONE;
		endcase
		return kind;
	endfunction

endpackage

>>> design/quadrature_decoder_speed.sv
// Quadrature decoder with speed estimate. Each input transfer carries a two-bit Gray
// code and a microsecond timestamp and yields exactly one result transfer with the
// position, the speed in signed 15.16 rotations per second, the step and an illegal
// flag. A clockwise or counter-clockwise step with a nonzero time difference passes
// through a restoring divider that produces one quotient bit per cycle; every other
// item skips the divider and goes straight to the result stage. One
// item is in work at a time, and a finished result waits in the output register
// while the next item is taken. The speed scale is written through the configuration
// channel, which is always ready; write it only while the block is idle.
module quadrature_decoder_speed (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [30:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          gray_code,
	input  logic [31:0]         event_time,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  position,
	output logic signed [31:0]  speed,
	output logic signed [1:0]   step,
	output logic                illegal
);
	import qds_pkg::*;

	ctrl_state_t state_q, state_d;

	logic [30:0] speed_scale_q;
	logic [1:0]  last_code_q;
	logic [31:0] count_q;
	logic [31:0] last_time_q;
	logic [31:0] rate_q;

	move_kind_t  kind_q;
	logic        zero_q;
	logic [31:0] delta_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  bit_cnt_q;

	logic        out_valid_q;
	logic [31:0] position_q;
	logic [31:0] speed_q;
	logic [1:0]  step_q;
	logic        illegal_q;

	logic        accept;
	logic        load_out;
	move_kind_t  kind_in;
	logic        is_move;
	logic [31:0] delta_in;
	logic [33:0] trial;
	logic [31:0] mag;
	logic [31:0] new_rate;

	assign kind_in = move_kind(last_code_q, gray_code);
	assign is_move = (kind_in == KIND_CW) || (kind_in == KIND_CCW);
	assign delta_in = event_time - last_time_q;
	assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, delta_q};
	assign mag = zero_q ? SPEED_SAT : quo_q;
	assign new_rate = (kind_q == KIND_CW) ? mag : 32'd0 - mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					accept = 1'b1;
					if (is_move && delta_in != 32'd0) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == 5'd31) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q <= SCALE_RESET;
			last_code_q <= 2'b00;
			count_q <= 32'd0;
			last_time_q <= 32'd0;
			rate_q <= 32'd0;
			out_valid_q <= 1'b0;
			bit_cnt_q <= 5'd0;
		end else begin
			if (cfg_valid) begin
				speed_scale_q <= cfg_data;
			end
			if (accept) begin
				last_code_q <= gray_code;
				bit_cnt_q <= 5'd0;
				if (kind_in == KIND_CW) begin
					count_q <= count_q + 32'd1;
					last_time_q <= event_time;
				end else if (kind_in == KIND_CCW) begin
					count_q <= count_q - 32'd1;
					last_time_q <= event_time;
				end
			end
			if (state_q == ST_DIV) begin
				bit_cnt_q <= bit_cnt_q + 5'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (kind_q == KIND_CW || kind_q == KIND_CCW) begin
					rate_q <= new_rate;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_in;
			zero_q <= (delta_in == 32'd0);
			delta_q <= delta_in;
			rem_q <= 32'd0;
			quo_q <= {1'b0, speed_scale_q};
		end else if (state_q == ST_DIV) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (load_out) begin
			position_q <= count_q;
			illegal_q <= (kind_q == KIND_ILLEGAL);
			case (kind_q)
				KIND_CW: begin
					speed_q <= new_rate;
					step_q <= STEP_CW;
				end
				KIND_CCW: begin
					speed_q <= new_rate;
					step_q <= STEP_CCW;
				end
				default: begin
					speed_q <= rate_q;
					step_q <= STEP_NONE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign position = position_q;
	assign speed = speed_q;
	assign step = step_q;
	assign illegal = illegal_q;

endmodule

>>> design/qds_checker.sv
module qds_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  speed,
	input  logic signed [1:0]   step,
	input  logic                illegal
);
	import qds_pkg::*;

	// A held result keeps its valid and its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position) && $stable(speed)
			&& $stable(step) && $stable(illegal))
		else $error("held result changed");

	// An illegal transition never reports a step.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> step == STEP_NONE)
		else $error("illegal transition reports a step");

	// The speed sign follows the step direction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step == STEP_CW |-> speed >= 0)
		else $error("clockwise step with negative speed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step == STEP_CCW |-> speed <= 0)
		else $error("counter-clockwise step with positive speed");

endmodule

bind quadrature_decoder_speed qds_checker u_qds_checker (.*);

>>> tb/quadrature_decoder_speed_tb.sv
module quadrature_decoder_speed_tb;
	import qds_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_pattern_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] speed;
		logic signed [1:0]  step;
		logic               illegal;
	} motion_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [30:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         gray_code = '0;
	logic [31:0]        event_time = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] position;
	logic signed [31:0] speed;
	logic signed [1:0]  step;
	logic               illegal;

	logic [30:0] scale_now = SCALE_RESET;
	logic [1:0]  code_now = '0;
	logic [31:0] count_now = '0;
	logic [31:0] change_time = '0;
	logic [31:0] speed_now = '0;
	motion_t     expected_motion[$];
	int          errors = 0;

	int             burst_left = 0;
	int             gap_max = 0;
	logic [31:0]    clock_us = '0;
	stall_pattern_t stall_mode = STALL_NONE;
	int             hold_req = 0;
	int             hold_taken = 0;
	int             hold_left = 0;
	int             stall_phase = 0;

	quadrature_decoder_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.gray_code (gray_code),
		.event_time(event_time),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.position  (position),
		.speed     (speed),
		.step      (step),
		.illegal   (illegal)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The step follows from the distance between the two codes along the Gray sequence.
	function automatic motion_t decode_event(input logic [1:0] code, input logic [31:0] t);
		logic [1:0]  from_pos;
		logic [1:0]  to_pos;
		logic [1:0]  turn;
		logic [31:0] delta;
		logic [31:0] magnitude;
		move_kind_t  kind;
		motion_t     m;
		from_pos = {code_now[1], ^code_now};
		to_pos = {code[1], ^code};
		turn = to_pos - from_pos;
		case (turn)
			2'd1: kind = KIND_CW;
			2'd2: kind = KIND_ILLEGAL;
			2'd3: kind = KIND_CCW;
			default: kind = KIND_NONE;
		endcase
		code_now = code;
		m.step = STEP_NONE;
		m.illegal = 1'b0;
		if (kind == KIND_CW || kind == KIND_CCW) begin
			delta = t - change_time;
			magnitude = (delta == 0) ? SPEED_SAT : {1'b0, scale_now} / delta;
			if (kind == KIND_CW) begin
				count_now = count_now + 1;
				speed_now = magnitude;
				m.step = STEP_CW;
			end else begin
				count_now = count_now - 1;
				speed_now = -magnitude;
				m.step = STEP_CCW;
			end
			change_time = t;
		end else if (kind == KIND_ILLEGAL) begin
			m.illegal = 1'b1;
		end
		m.position = count_now;
		m.speed = speed_now;
		return m;
	endfunction

	task automatic send_event(input logic [1:0] code, input logic [31:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		in_valid <= 1'b1;
		gray_code <= code;
		event_time <= t;
		do @(posedge clk); while (in_stall);
		expected_motion.push_back(decode_event(code, t));
	endtask

	// Mostly legal rotation with random timing, plus repeats, illegal jumps and wild timestamps.
	task automatic walk_step();
		int          pick;
		logic [1:0]  pos;
		logic [31:0] delta;
		pick = $urandom_range(0, 99);
		pos = {code_now[1], ^code_now};
		if (pick < 44)
			pos = pos + 2'd1;
		else if (pick < 86)
			pos = pos - 2'd1;
		else if (pick < 93)
			pos = pos + 2'd2;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			delta = 0;
		else if (pick == 1)
			delta = $urandom;
		else if (pick < 6)
			delta = $urandom_range(1, 20);
		else
			delta = $urandom_range(20, 5000);
		clock_us = clock_us + delta;
		send_event({pos[1], pos[1] ^ pos[0]}, clock_us);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_motion.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_scale(input logic [30:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		scale_now = value;
	endtask

	task automatic randomize_idling();
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		stall_mode <= stall_pattern_t'($urandom_range(0, 2));
	endtask

	task automatic test_directed();
		gap_max = 0;
		stall_mode <= STALL_NONE;
		send_event(2'b00, 32'd0);
		send_event(2'b01, 32'd0);
		send_event(2'b00, 32'd0);
		send_event(2'b11, 32'd7);
		send_event(2'b11, 32'd9);
		send_event(2'b01, 32'd100);
		send_event(2'b00, 32'hFFFF_FFFF);
		send_event(2'b01, 32'd5);
		send_event(2'b11, 32'd1005);
		send_event(2'b10, 32'h8000_0000);
		send_event(2'b00, 32'h8000_0001);
		send_event(2'b01, 32'h7FFF_FFFF);
		send_event(2'b10, 32'h7FFF_FFFF);
		send_event(2'b11, 32'h7FFF_FFFF);
		send_event(2'b01, 32'h5555_5555);
		send_event(2'b10, 32'hAAAA_AAAA);
		send_event(2'b01, 32'hAAAA_AAAA);
		send_event(2'b00, 32'hAAAA_AAAB);
		wait_idle();
		clock_us = 32'hAAAA_AAAB;
	endtask

	task automatic test_scale_settings();
		logic [30:0] settings[5];
		settings[0] = 31'd0;
		settings[1] = 31'd1;
		settings[2] = 31'h7FFF_FFFF;
		settings[3] = 31'($urandom);
		settings[4] = SCALE_RESET;
		foreach (settings[i]) begin
			write_scale(settings[i]);
			randomize_idling();
			repeat (150) walk_step();
			wait_idle();
		end
	endtask

	task automatic test_random_walk();
		repeat (10) begin
			randomize_idling();
			repeat (100) walk_step();
		end
		wait_idle();
	endtask

	task automatic test_back_pressure();
		gap_max = 0;
		stall_mode <= STALL_NONE;
		hold_req <= hold_req + 1;
		repeat (40) walk_step();
		wait_idle();
		stall_mode <= STALL_RANDOM;
		repeat (20) walk_step();
		wait_idle();
	endtask

	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_taken != hold_req) begin
			hold_taken <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
				STALL_PATTERN: out_stall <= (stall_phase % 7 < 3);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	function automatic void compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		motion_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_motion.size() == 0) begin
				errors++;
				$display("%0t: result transfer with none expected, actual position %0d speed %0d",
					$time, position, speed);
			end else begin
				want = expected_motion.pop_front();
				compare_field("position", want.position, position);
				compare_field("speed", want.speed, speed);
				compare_field("step", 32'(want.step), 32'(step));
				compare_field("illegal", 32'(want.illegal), 32'(illegal));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_scale_settings();
		test_random_walk();
		test_back_pressure();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_motion.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
